FILE: hw/rtl/window_zscore_spike_detector_assert.svh
// assertion macros shared by the spike detector checkers
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef WINDOW_ZSCORE_SPIKE_DETECTOR_ASSERT_SVH
`define WINDOW_ZSCORE_SPIKE_DETECTOR_ASSERT_SVH

// same-cycle implication
`define WZSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WZSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wzsd_pkg.sv
// types, constants and the step program of the window z-score spike detector
// no dependencies; used by every rtl module of the block
package wzsd_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int KIND_W    = 3;
  localparam int CLS_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int LIMB_W    = 32;
  localparam int OPND_W    = 4 * LIMB_W;
  localparam int ACC_W     = 128;
  localparam int SHIFT_W   = 3;
  localparam int PC_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG   = 1'b1;

  localparam logic [CFG_W-1:0] SMALL_RESET = 16'd768;
  localparam logic [CFG_W-1:0] BIG_RESET   = 16'd1280;

  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  localparam logic [SAMPLE_W-1:0] SMALL_LIMIT = 24'd1000000;
  localparam logic [SAMPLE_W-1:0] BIG_LIMIT   = 24'd10000000;

  localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SMALL = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BIG   = 2'd2;

  localparam logic [PC_W-1:0] CLASS_START = 6'd8;
  localparam logic [PC_W-1:0] PROG_LAST   = 6'd33;

  typedef struct packed {
    logic [SAMPLE_W-1:0] latency;
    logic [KIND_W-1:0]   op_kind;
  } in_beat_t;

  typedef struct packed {
    logic [CLS_W-1:0] spike_class;
    logic             window_full;
  } out_beat_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_N,
    SRC_X,
    SRC_OLD,
    SRC_S,
    SRC_Q,
    SRC_D,
    SRC_VAR,
    SRC_T2,
    SRC_TBIG,
    SRC_TSML
  } src_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_mode_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_SUM,
    WB_SQ,
    WB_DEV,
    WB_VAR,
    WB_T2,
    WB_BIG
  } store_e;

  typedef struct packed {
    acc_mode_e            mode;
    logic [SHIFT_W-1:0]   shift;
  } mac_ctl_t;

  typedef struct packed {
    src_e        a_src;
    logic [1:0]  a_limb;
    src_e        b_src;
    logic [1:0]  b_limb;
    mac_ctl_t    mac;
    store_e      store;
  } op_t;

  function automatic op_t mk(input src_e a, input logic [1:0] al, input src_e b,
                             input logic [1:0] bl, input acc_mode_e m,
                             input logic [SHIFT_W-1:0] sh, input store_e wb);
    op_t op;
    op.a_src      = a;
    op.a_limb     = al;
    op.b_src      = b;
    op.b_limb     = bl;
    op.mac.mode   = m;
    op.mac.shift  = sh;
    op.store      = wb;
    return op;
  endfunction

  // shift is in units of 16 bits; a store sees the sum of the earlier steps since the last load
  function automatic op_t prog_op(input logic [PC_W-1:0] pc);
    op_t op;
    op = mk(SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, ACC_HOLD, 3'd0, WB_NONE);
    case (pc)
      // window update: sum
      6'd0:  op = mk(SRC_X,    2'd0, SRC_ONE,  2'd0, ACC_LOAD, 3'd0, WB_NONE);
      6'd1:  op = mk(SRC_S,    2'd0, SRC_ONE,  2'd0, ACC_ADD,  3'd0, WB_NONE);
      6'd2:  op = mk(SRC_S,    2'd1, SRC_ONE,  2'd0, ACC_ADD,  3'd2, WB_NONE);
      6'd3:  op = mk(SRC_OLD,  2'd0, SRC_ONE,  2'd0, ACC_SUB,  3'd0, WB_NONE);
      // window update: sum of squares
      6'd4:  op = mk(SRC_X,    2'd0, SRC_X,    2'd0, ACC_LOAD, 3'd0, WB_SUM);
      6'd5:  op = mk(SRC_Q,    2'd0, SRC_ONE,  2'd0, ACC_ADD,  3'd0, WB_NONE);
      6'd6:  op = mk(SRC_Q,    2'd1, SRC_ONE,  2'd0, ACC_ADD,  3'd2, WB_NONE);
      6'd7:  op = mk(SRC_OLD,  2'd0, SRC_OLD,  2'd0, ACC_SUB,  3'd0, WB_NONE);
      // deviation n*x - s
      6'd8:  op = mk(SRC_X,    2'd0, SRC_N,    2'd0, ACC_LOAD, 3'd0, WB_SQ);
      6'd9:  op = mk(SRC_S,    2'd0, SRC_ONE,  2'd0, ACC_SUB,  3'd0, WB_NONE);
      6'd10: op = mk(SRC_S,    2'd1, SRC_ONE,  2'd0, ACC_SUB,  3'd2, WB_NONE);
      // scaled variance n*q - s^2
      6'd11: op = mk(SRC_N,    2'd0, SRC_Q,    2'd0, ACC_LOAD, 3'd0, WB_DEV);
      6'd12: op = mk(SRC_N,    2'd0, SRC_Q,    2'd1, ACC_ADD,  3'd2, WB_NONE);
      6'd13: op = mk(SRC_S,    2'd0, SRC_S,    2'd0, ACC_SUB,  3'd0, WB_NONE);
      6'd14: op = mk(SRC_S,    2'd0, SRC_S,    2'd1, ACC_SUB,  3'd2, WB_NONE);
      6'd15: op = mk(SRC_S,    2'd1, SRC_S,    2'd0, ACC_SUB,  3'd2, WB_NONE);
      6'd16: op = mk(SRC_S,    2'd1, SRC_S,    2'd1, ACC_SUB,  3'd4, WB_NONE);
      // big threshold: 65536*d^2 - t^2*var
      6'd17: op = mk(SRC_TBIG, 2'd0, SRC_TBIG, 2'd0, ACC_LOAD, 3'd0, WB_VAR);
      6'd18: op = mk(SRC_D,    2'd0, SRC_D,    2'd0, ACC_LOAD, 3'd1, WB_T2);
      6'd19: op = mk(SRC_D,    2'd0, SRC_D,    2'd1, ACC_ADD,  3'd3, WB_NONE);
      6'd20: op = mk(SRC_D,    2'd1, SRC_D,    2'd0, ACC_ADD,  3'd3, WB_NONE);
      6'd21: op = mk(SRC_D,    2'd1, SRC_D,    2'd1, ACC_ADD,  3'd5, WB_NONE);
      6'd22: op = mk(SRC_VAR,  2'd0, SRC_T2,   2'd0, ACC_SUB,  3'd0, WB_NONE);
      6'd23: op = mk(SRC_VAR,  2'd1, SRC_T2,   2'd0, ACC_SUB,  3'd2, WB_NONE);
      6'd24: op = mk(SRC_VAR,  2'd2, SRC_T2,   2'd0, ACC_SUB,  3'd4, WB_NONE);
      // small threshold, result left in the accumulator
      6'd25: op = mk(SRC_TSML, 2'd0, SRC_TSML, 2'd0, ACC_LOAD, 3'd0, WB_BIG);
      6'd26: op = mk(SRC_D,    2'd0, SRC_D,    2'd0, ACC_LOAD, 3'd1, WB_T2);
      6'd27: op = mk(SRC_D,    2'd0, SRC_D,    2'd1, ACC_ADD,  3'd3, WB_NONE);
      6'd28: op = mk(SRC_D,    2'd1, SRC_D,    2'd0, ACC_ADD,  3'd3, WB_NONE);
      6'd29: op = mk(SRC_D,    2'd1, SRC_D,    2'd1, ACC_ADD,  3'd5, WB_NONE);
      6'd30: op = mk(SRC_VAR,  2'd0, SRC_T2,   2'd0, ACC_SUB,  3'd0, WB_NONE);
      6'd31: op = mk(SRC_VAR,  2'd1, SRC_T2,   2'd0, ACC_SUB,  3'd2, WB_NONE);
      6'd32: op = mk(SRC_VAR,  2'd2, SRC_T2,   2'd0, ACC_SUB,  3'd4, WB_NONE);
      default: ;
    endcase
    return op;
  endfunction

endpackage

FILE: hw/rtl/wzsd_ring.sv
// sample ring of the spike detector, one read-first port with registered read
// depends on wzsd_pkg for the sample width
module wzsd_ring #(
  parameter int DEPTH = 64,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [IW-1:0]                 addr_i,
  input  logic [wzsd_pkg::SAMPLE_W-1:0] wdata_i,
  output logic [wzsd_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [wzsd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [wzsd_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wzsd_mac.sv
// shared 32x32 multiplier with registered product and a wide accumulator
// depends on wzsd_pkg for the control struct and widths
module wzsd_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wzsd_pkg::LIMB_W-1:0] a_i,
  input  logic [wzsd_pkg::LIMB_W-1:0] b_i,
  input  wzsd_pkg::mac_ctl_t          ctl_i,
  output logic [wzsd_pkg::ACC_W-1:0]  acc_o
);

  localparam int PW = 2 * wzsd_pkg::LIMB_W;
  localparam int AW = wzsd_pkg::ACC_W;

  logic [PW-1:0]      prod_q;
  wzsd_pkg::mac_ctl_t ctl_q;
  logic [AW-1:0]      acc_q;
  logic [AW-1:0]      acc_d;
  logic [AW-1:0]      shifted;
  logic [wzsd_pkg::SHIFT_W+3:0] shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{mode: wzsd_pkg::ACC_HOLD, shift: '0};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(a_i) * PW'(b_i);
    acc_q  <= acc_d;
  end

  // shift in steps of 16 bits
  assign shamt   = {ctl_q.shift, 4'b0000};
  assign shifted = AW'(prod_q) << shamt;

  always_comb begin
    case (ctl_q.mode)
      wzsd_pkg::ACC_LOAD: acc_d = shifted;
      wzsd_pkg::ACC_ADD:  acc_d = acc_q + shifted;
      wzsd_pkg::ACC_SUB:  acc_d = acc_q - shifted;
      default:            acc_d = acc_q;
    endcase
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/window_zscore_spike_detector.sv
// top level of the sliding window z-score spike detector
// depends on wzsd_pkg, wzsd_ring and wzsd_mac
//
//  channel | direction | handshake                | beat
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (latency, op_kind)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (spike_class, window_full)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// a beat runs to its end before the next beat is accepted, with
// one partial product per cycle through the shared 32x32 multiply-accumulate unit
// over a 34 step program (26 steps when the window is left unchanged)
// after reset the window is empty; the ring holds no valid data and needs no clearing
// a new beat is taken while a result waits; a stalled result holds the block in its
// last step until the output register frees
module window_zscore_spike_detector #(
  parameter int WINDOW = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wzsd_pkg::in_beat_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wzsd_pkg::out_beat_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [wzsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wzsd_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int LOGW   = $clog2(WINDOW);
  localparam int IDX_W  = LOGW;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = wzsd_pkg::SAMPLE_W + LOGW;
  localparam int SQ_W   = 2 * wzsd_pkg::SAMPLE_W + LOGW;
  localparam int VAR_W  = SQ_W + LOGW;
  localparam int OW     = wzsd_pkg::OPND_W;
  localparam int LW     = wzsd_pkg::LIMB_W;
  localparam int AW     = wzsd_pkg::ACC_W;
  localparam int SW     = wzsd_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e                    state_q;
  logic [wzsd_pkg::PC_W-1:0] pc_q;
  logic                      push_q;
  logic                      drop_q;
  wzsd_pkg::store_e          str_q;
  wzsd_pkg::out_beat_t       out_q;
  logic                      out_valid_q;

  logic [wzsd_pkg::CFG_W-1:0] thr_small_q;
  logic [wzsd_pkg::CFG_W-1:0] thr_big_q;

  logic [FILL_W-1:0] fill_q;
  logic [IDX_W-1:0]  oldest_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SW-1:0]     newest_q;
  logic [SUM_W-1:0]  dev_q;
  logic [VAR_W-1:0]  var_q;
  logic [2*wzsd_pkg::CFG_W-1:0] t2_q;
  logic              big_q;

  logic              in_fire;
  logic              is_push;
  logic              full;
  logic              running;
  logic [IDX_W-1:0]  ring_addr;
  logic [SW-1:0]     ring_rd;
  logic [SW-1:0]     old_smp;
  wzsd_pkg::op_t     op;
  wzsd_pkg::mac_ctl_t mac_ctl;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     acc_abs;
  logic              acc_neg;
  logic              acc_pos;
  logic              out_free;
  wzsd_pkg::out_beat_t result;

  wzsd_pkg::src_e    sel_src [2];
  logic [1:0]        sel_limb [2];
  logic [OW-1:0]     opnd_full [2];
  logic [LW-1:0]     opnd_limb [2];

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_push     = (in_data_i.op_kind <= wzsd_pkg::KIND_DELETE);
  assign full        = (fill_q == FILL_W'(WINDOW));
  assign running     = (state_q == S_RUN);
  assign ring_addr   = full ? oldest_q : fill_q[IDX_W-1:0];
  assign old_smp     = drop_q ? ring_rd : '0;
  assign out_free    = !out_valid_q || out_ready_i;

  wzsd_ring #(
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (in_fire),
    .we_i    (in_fire && is_push),
    .addr_i  (ring_addr),
    .wdata_i (in_data_i.latency),
    .rdata_o (ring_rd)
  );

  assign op      = wzsd_pkg::prog_op(pc_q);
  assign mac_ctl = running ? op.mac : '{mode: wzsd_pkg::ACC_HOLD, shift: '0};

  assign sel_src[0]  = op.a_src;
  assign sel_src[1]  = op.b_src;
  assign sel_limb[0] = op.a_limb;
  assign sel_limb[1] = op.b_limb;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      unique case (sel_src[k])
        wzsd_pkg::SRC_ZERO: opnd_full[k] = '0;
        wzsd_pkg::SRC_ONE:  opnd_full[k] = OW'(1);
        wzsd_pkg::SRC_N:    opnd_full[k] = OW'(WINDOW);
        wzsd_pkg::SRC_X:    opnd_full[k] = OW'(newest_q);
        wzsd_pkg::SRC_OLD:  opnd_full[k] = OW'(old_smp);
        wzsd_pkg::SRC_S:    opnd_full[k] = OW'(sum_q);
        wzsd_pkg::SRC_Q:    opnd_full[k] = OW'(sq_q);
        wzsd_pkg::SRC_D:    opnd_full[k] = OW'(dev_q);
        wzsd_pkg::SRC_VAR:  opnd_full[k] = OW'(var_q);
        wzsd_pkg::SRC_T2:   opnd_full[k] = OW'(t2_q);
        wzsd_pkg::SRC_TBIG: opnd_full[k] = OW'(thr_big_q);
        wzsd_pkg::SRC_TSML: opnd_full[k] = OW'(thr_small_q);
        default:            opnd_full[k] = '0;
      endcase
      opnd_limb[k] = opnd_full[k][LW*sel_limb[k] +: LW];
    end
  end

  wzsd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (opnd_limb[0]),
    .b_i    (opnd_limb[1]),
    .ctl_i  (mac_ctl),
    .acc_o  (acc)
  );

  assign acc_neg = acc[AW-1];
  assign acc_pos = !acc_neg && (acc != '0);
  assign acc_abs = acc_neg ? (~acc + AW'(1)) : acc;

  always_comb begin
    result.window_full = full;
    if (!full) begin
      result.spike_class = wzsd_pkg::CLS_NONE;
    end else if (big_q || (newest_q > wzsd_pkg::BIG_LIMIT)) begin
      result.spike_class = wzsd_pkg::CLS_BIG;
    end else if (acc_pos || (newest_q > wzsd_pkg::SMALL_LIMIT)) begin
      result.spike_class = wzsd_pkg::CLS_SMALL;
    end else begin
      result.spike_class = wzsd_pkg::CLS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      push_q      <= 1'b0;
      drop_q      <= 1'b0;
      str_q       <= wzsd_pkg::WB_NONE;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      str_q <= running ? op.store : wzsd_pkg::WB_NONE;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_RUN;
            pc_q    <= is_push ? '0 : wzsd_pkg::CLASS_START;
            push_q  <= is_push;
            drop_q  <= is_push && full;
          end
        end
        S_RUN: begin
          if (pc_q == wzsd_pkg::PROG_LAST) begin
            state_q <= S_FIN;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q   <= result;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_small_q <= wzsd_pkg::SMALL_RESET;
      thr_big_q   <= wzsd_pkg::BIG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wzsd_pkg::CFG_SMALL: thr_small_q <= cfg_data_i;
        wzsd_pkg::CFG_BIG:   thr_big_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      newest_q <= '0;
    end else begin
      if (in_fire && is_push) begin
        newest_q <= in_data_i.latency;
        if (full) begin
          oldest_q <= (oldest_q == IDX_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
        end else begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (push_q && (str_q == wzsd_pkg::WB_SUM)) begin
        sum_q <= acc[SUM_W-1:0];
      end
      if (push_q && (str_q == wzsd_pkg::WB_SQ)) begin
        sq_q <= acc[SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (str_q)
      wzsd_pkg::WB_DEV: dev_q <= acc_abs[SUM_W-1:0];
      wzsd_pkg::WB_VAR: var_q <= acc_neg ? '0 : acc[VAR_W-1:0];
      wzsd_pkg::WB_T2:  t2_q  <= acc[2*wzsd_pkg::CFG_W-1:0];
      wzsd_pkg::WB_BIG: big_q <= acc_pos;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/wzsd_checker.sv
// port-level checker for the spike detector, attached to the top level by bind
// depends on wzsd_pkg and window_zscore_spike_detector_assert.svh
`include "window_zscore_spike_detector_assert.svh"

module wzsd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input wzsd_pkg::out_beat_t            out_data_o
);

  logic in_beat;
  logic out_stall;
  logic out_empty;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_empty = !out_valid_o || out_ready_i;

  `WZSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o), "stalled result changed")
  `WZSD_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_beat, !in_ready_o, "input taken while busy")
  `WZSD_ASSERT_NEXT(a_no_instant_out, clk_i, rst_ni, in_beat && out_empty, !out_valid_o, "result too early")
  `WZSD_ASSERT_NOW(a_ready_with_out, clk_i, rst_ni, $rose(out_valid_o), in_ready_o, "result without idle")

endmodule

bind window_zscore_spike_detector wzsd_checker u_wzsd_checker (.*);
